>>> hdl/crl_pkg.sv
// Shared types and codes for the CIGAR reference-length block.
// No dependencies; imported by every module of the block.
`default_nettype none

package crl_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_STAR,
    PH_SPACE,
    PH_SIGN,
    PH_DIGITS,
    PH_BOUNDARY,
    PH_ERROR
  } phase_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  // characters with a fixed meaning in a CIGAR string
  localparam logic [7:0] CH_TAB   = 8'd9;   // first of the TAB..CR blank run
  localparam logic [7:0] CH_CR    = 8'd13;  // last of the TAB..CR blank run
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // operation characters
  localparam logic [7:0] OP_EQ = 8'd61;  // '='
  localparam logic [7:0] OP_D  = 8'd68;
  localparam logic [7:0] OP_H  = 8'd72;
  localparam logic [7:0] OP_I  = 8'd73;
  localparam logic [7:0] OP_M  = 8'd77;
  localparam logic [7:0] OP_N  = 8'd78;
  localparam logic [7:0] OP_P  = 8'd80;
  localparam logic [7:0] OP_S  = 8'd83;
  localparam logic [7:0] OP_X  = 8'd88;

  typedef struct packed {
    logic [31:0] ref_length;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/crl_parser.sv
// Character parser: phase register, count accumulator and saturating total.
// Depends on crl_pkg.
`default_nettype none

module crl_parser import crl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,      // one character request processed
  input  wire logic [7:0] symbol_i,
  input  wire logic       end_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] mag_q, mag_d;       // up to 2^31
  logic        neg_q, neg_d;
  logic [31:0] total_q, total_d;
  logic        sat_q, sat_d;

  logic        is_space, is_digit, is_sign, consumes;
  logic [34:0] mag_next;
  logic        mag_over;
  logic [32:0] cnt;
  logic        cnt_clamp;
  logic [33:0] sum;
  logic        sum_hi, sum_lo;
  logic [31:0] sum_clamped;

  assign is_space = (symbol_i == CH_SPACE) || (symbol_i >= CH_TAB && symbol_i <= CH_CR);
  assign is_digit = (symbol_i >= CH_ZERO) && (symbol_i <= CH_NINE);
  assign is_sign  = (symbol_i == CH_PLUS) || (symbol_i == CH_MINUS);
  assign consumes = (symbol_i == OP_M) || (symbol_i == OP_D) || (symbol_i == OP_N) ||
                    (symbol_i == OP_EQ) || (symbol_i == OP_X);

  // mag * 10 + digit; a digit's value is its low nibble
  assign mag_next = ({3'b000, mag_q} << 3) + ({3'b000, mag_q} << 1) +
                    {31'd0, symbol_i[3:0]};
  assign mag_over = mag_next > 35'h0_8000_0000;

  // signed count; a positive 2^31 clamps to the max
  always_comb begin
    cnt_clamp = 1'b0;
    if (neg_q) begin
      cnt = 33'd0 - {1'b0, mag_q};
    end else if (mag_q[31]) begin
      cnt       = 33'h0_7FFF_FFFF;
      cnt_clamp = 1'b1;
    end else begin
      cnt = {1'b0, mag_q};
    end
  end

  assign sum    = {{2{total_q[31]}}, total_q} + {cnt[32], cnt};
  assign sum_hi = !sum[33] && (sum[32:31] != 2'b00);
  assign sum_lo = sum[33] && (sum[32:31] != 2'b11);
  always_comb begin
    priority if (sum_hi) begin
      sum_clamped = 32'h7FFF_FFFF;
    end else if (sum_lo) begin
      sum_clamped = 32'h8000_0000;
    end else begin
      sum_clamped = sum[31:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    total_d = total_q;
    sat_d   = sat_q;
    res_o.ref_length = 32'd0;
    res_o.status     = ST_OK;
    unique case (phase_q)
      PH_START:    ;
      PH_STAR:     res_o.ref_length = 32'hFFFF_FFFF;
      PH_BOUNDARY: begin
        res_o.ref_length = total_q;
        res_o.status     = sat_q ? ST_SATURATED : ST_OK;
      end
      default:     res_o.status = ST_MALFORMED;
    endcase

    if (end_i) begin
      phase_d = PH_START;
      mag_d   = 32'd0;
      neg_d   = 1'b0;
      total_d = 32'd0;
      sat_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_START, PH_SPACE, PH_BOUNDARY: begin
          priority if (phase_q == PH_START && symbol_i == CH_STAR) begin
            phase_d = PH_STAR;
          end else if (is_space) begin
            phase_d = PH_SPACE;
          end else if (is_digit || is_sign) begin
            neg_d   = (symbol_i == CH_MINUS);
            mag_d   = is_digit ? {28'd0, symbol_i[3:0]} : 32'd0;
            phase_d = is_digit ? PH_DIGITS : PH_SIGN;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            mag_d   = {28'd0, symbol_i[3:0]};
            phase_d = PH_DIGITS;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (mag_over) begin
              mag_d = 32'h8000_0000;
              sat_d = 1'b1;
            end else begin
              mag_d = mag_next[31:0];
            end
          end else begin
            // any non-digit closes the element as its operation
            if (cnt_clamp) sat_d = 1'b1;
            if (consumes) begin
              total_d = sum_clamped;
              if (sum_hi || sum_lo) sat_d = 1'b1;
            end
            phase_d = PH_BOUNDARY;
          end
        end
        default: phase_d = PH_ERROR;
      endcase
    end
  end

  assign res_valid_o = step_i && end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      mag_q   <= 32'd0;
      neg_q   <= 1'b0;
      total_q <= 32'd0;
      sat_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      total_q <= total_d;
      sat_q   <= sat_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/crl_out_skid.sv
// Result register with a skid entry, decoupling the parser from the sink.
// Depends on crl_pkg.
`default_nettype none

module crl_out_skid import crl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  result_t      push_data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    pop_ready_i,
  output result_t      data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      // skid is empty whenever a push is taken
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end else if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cigar_reference_length.sv
// CIGAR reference length: one character per cycle when not stalled, one result per string.
// End-marker path: input register, then the result buffer's main register.
// Throughput: one request per cycle while the result buffer has room, set by the
// parser update (multiply-by-ten add or saturating total add) on the phase registers.
// Reset (async, active low) returns the parser to start of string and empties
// the input register and the result buffer. Depends on crl_pkg, crl_parser, crl_out_skid.
`default_nettype none

module cigar_reference_length import crl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic        s_axis_tlast,   // end_of_string
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] ref_length
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_sym_q;
  logic       in_last_q;

  logic       advance;
  logic       buf_ready;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // the parser advances whenever the result buffer has room; that holds
  // even while a finished result sits in the main register
  assign advance       = in_valid_q && buf_ready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sym_q  <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  crl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .symbol_i    (in_sym_q),
    .end_i       (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crl_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = out_data.ref_length;
  assign m_axis_tuser = out_data.status;

endmodule

`default_nettype wire

>>> tb/sv/tb_cigar_reference_length.sv
`timescale 1ns / 100ps
// Self-checking testbench for cigar_reference_length: streams CIGAR strings one
// character per request and checks each reference length and status against an in-bench
// parser or the directed table. Depends on crl_pkg and the cigar_reference_length RTL.

module tb_cigar_reference_length;
  import crl_pkg::*;

  localparam int     N_DIRECTED   = 23;
  localparam int     N_RAND_CHARS = 480;
  localparam int     HOLD_CYCLES  = 400;  // long result-side stall
  localparam int     HOLD_AFTER   = 200;  // characters accepted before the stall
  localparam int     DRAIN_CYCLES = 10;   // extra margin after the last result is checked
  localparam longint LEN_MAX      = 64'sd2147483647;
  localparam longint LEN_MIN      = -64'sd2147483648;
  localparam longint MAG_CAP      = 64'sd2147483648;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // [7:0] symbol
  logic        s_axis_tlast  = 1'b0;  // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [31:0] ref_length
  logic [1:0]  m_axis_tuser;          // [1:0] status

  cigar_reference_length uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Types and the directed string table
  // ---------------------------------------------------------------------------
  // One directed string. sub_pos/sub_val patch in a byte that a string literal
  // can't carry (TAB, NUL, high codes). has_exp marks rows whose answer is
  // obvious; the rest are checked against the parser below.
  typedef struct {
    string      text;
    int         sub_pos;
    logic [7:0] sub_val;
    bit         has_exp;
    logic [31:0] exp_len;
    logic [1:0] exp_st;
  } cigar_row_t;

  typedef struct {
    logic [7:0] sym;
    bit         eos;
    bit         has_exp;
    result_t    exp;
  } char_req_t;

  cigar_row_t dir_rows [N_DIRECTED] = '{
    '{"",                -1, 8'h00, 1'b1, 32'd0,          ST_OK},        // empty string
    '{"*",               -1, 8'h00, 1'b1, 32'hFFFF_FFFF,  ST_OK},        // lone star
    '{"*M",              -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // star plus more
    '{"10M5I3D",         -1, 8'h00, 1'b0, 32'd0,          ST_OK},
    '{"1M1D1N1=1X1S1H1P",-1, 8'h00, 1'b0, 32'd0,          ST_OK},        // every op but I
    '{"x+5M-2D",          0, CH_TAB, 1'b0, 32'd0,         ST_OK},        // TAB, signs
    '{"   ",             -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // blanks only
    '{"12",              -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // count, no op
    '{"-",               -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // lone sign
    '{"M",               -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // op first
    '{"x5M",              0, 8'hFF, 1'b1, 32'd0,          ST_MALFORMED}, // high code first
    '{"2147483647M",     -1, 8'h00, 1'b1, 32'h7FFF_FFFF,  ST_OK},
    '{"2147483648M",     -1, 8'h00, 1'b1, 32'h7FFF_FFFF,  ST_SATURATED},
    '{"-2147483648M",    -1, 8'h00, 1'b1, 32'h8000_0000,  ST_OK},
    '{"99999999999D",    -1, 8'h00, 1'b1, 32'h7FFF_FFFF,  ST_SATURATED}, // count clamp
    '{"2147483647M1X",   -1, 8'h00, 1'b1, 32'h7FFF_FFFF,  ST_SATURATED}, // total clamp up
    '{"-2147483648M-1D", -1, 8'h00, 1'b1, 32'h8000_0000,  ST_SATURATED}, // total clamp down
    '{"3 4M",            -1, 8'h00, 1'b0, 32'd0,          ST_OK},        // blank as op
    '{"7x6N",             1, 8'h00, 1'b0, 32'd0,          ST_OK},        // NUL as op
    '{"1M 2M",           -1, 8'h00, 1'b0, 32'd0,          ST_OK},
    '{"5M+",             -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}, // dangling sign
    '{"-0M007=",         -1, 8'h00, 1'b0, 32'd0,          ST_OK},
    '{"2M*",             -1, 8'h00, 1'b1, 32'd0,          ST_MALFORMED}  // star mid-string
  };

  // ---------------------------------------------------------------------------
  // Parser prediction: same phases as the RTL, own copy of the state
  // ---------------------------------------------------------------------------
  phase_e      p_phase = PH_START;
  logic [31:0] p_mag   = '0;     // holds up to 2^31
  bit          p_neg   = 1'b0;
  longint      p_total = 0;
  bit          p_sat   = 1'b0;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_ref_op(logic [7:0] c);
    return c == OP_M || c == OP_D || c == OP_N || c == OP_EQ || c == OP_X;
  endfunction

  // Advance the parser by one character; returns 1 with the string's result
  // when eos is set.
  function automatic bit predict_cigar_char(logic [7:0] c, bit eos, output result_t res);
    longint v;
    longint cnt;
    res = '0;
    if (eos) begin
      case (p_phase)
        PH_START:    res.ref_length = '0;
        PH_STAR:     res.ref_length = '1;
        PH_BOUNDARY: begin
          res.ref_length = p_total[31:0];
          res.status     = p_sat ? ST_SATURATED : ST_OK;
        end
        default:     res.status = ST_MALFORMED;
      endcase
      p_phase = PH_START;
      p_mag   = '0;
      p_neg   = 1'b0;
      p_total = 0;
      p_sat   = 1'b0;
      return 1'b1;
    end
    case (p_phase)
      PH_START, PH_SPACE, PH_BOUNDARY: begin
        if (p_phase == PH_START && c == CH_STAR) begin
          p_phase = PH_STAR;
        end else if (is_blank(c)) begin
          p_phase = PH_SPACE;
        end else if (is_num(c) || c == CH_PLUS || c == CH_MINUS) begin
          p_neg   = (c == CH_MINUS);
          p_mag   = is_num(c) ? {24'd0, c} - {24'd0, CH_ZERO} : '0;
          p_phase = is_num(c) ? PH_DIGITS : PH_SIGN;
        end else begin
          p_phase = PH_ERROR;
        end
      end
      PH_SIGN: begin
        if (is_num(c)) begin
          p_mag   = {24'd0, c} - {24'd0, CH_ZERO};
          p_phase = PH_DIGITS;
        end else begin
          p_phase = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (is_num(c)) begin
          v = longint'(p_mag) * 10 + longint'(c) - longint'(CH_ZERO);
          if (v > MAG_CAP) begin
            v     = MAG_CAP;
            p_sat = 1'b1;
          end
          p_mag = v[31:0];
        end else begin
          // any non-digit closes the count and acts as the op
          cnt = p_neg ? -longint'(p_mag) : longint'(p_mag);
          if (cnt > LEN_MAX) begin
            cnt   = LEN_MAX;
            p_sat = 1'b1;
          end
          if (is_ref_op(c)) begin
            v = p_total + cnt;
            if (v > LEN_MAX) begin
              v     = LEN_MAX;
              p_sat = 1'b1;
            end else if (v < LEN_MIN) begin
              v     = LEN_MIN;
              p_sat = 1'b1;
            end
            p_total = v;
          end
          p_phase = PH_BOUNDARY;
        end
      end
      default: p_phase = PH_ERROR;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  char_req_t send_q[$];

  // Queue a string's characters followed by its end marker. The symbol on
  // the end marker is don't-care, so it gets random bits.
  function automatic void push_string(logic [7:0] s[$], bit has_exp, result_t exp);
    char_req_t r;
    foreach (s[i]) begin
      r.sym     = s[i];
      r.eos     = 1'b0;
      r.has_exp = 1'b0;
      r.exp     = '0;
      send_q.push_back(r);
    end
    r.sym     = 8'($urandom_range(0, 255));
    r.eos     = 1'b1;
    r.has_exp = has_exp;
    r.exp     = exp;
    send_q.push_back(r);
  endfunction

  // Well-formed CIGAR with random content: small counts mostly, some near and
  // past the 32-bit edge so totals saturate now and then.
  function automatic void build_cigar(ref logic [7:0] s[$]);
    logic [7:0] ops [9];
    string      num;
    int         n_el;
    int         pick;
    int         ws;
    logic [7:0] c;
    ops  = '{OP_M, OP_I, OP_D, OP_N, OP_S, OP_H, OP_P, OP_EQ, OP_X};
    n_el = $urandom_range(1, 5);
    for (int e = 0; e < n_el; e++) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          ws = $urandom_range(0, 5);
          s.push_back(ws == 0 ? CH_SPACE : 8'(int'(CH_TAB) + ws - 1));
        end
      end
      if ($urandom_range(0, 9) == 0) s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(0, 15) == 0) s.push_back(CH_ZERO);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        num = $sformatf("%0d", $urandom_range(0, 999));
      end else if (pick < 85) begin
        num = $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
      end else if (pick < 95) begin
        num = $sformatf("%0d", 64'd2147483640 + $urandom_range(0, 15));
      end else begin
        num = $sformatf("%0d", $urandom_range(1, 9));
        repeat ($urandom_range(10, 12)) num = {num, $sformatf("%0d", $urandom_range(0, 9))};
      end
      for (int i = 0; i < num.len(); i++) s.push_back(8'(num[i]));
      if ($urandom_range(0, 9) != 0) begin
        s.push_back(ops[$urandom_range(0, 8)]);
      end else begin
        do c = 8'($urandom_range(0, 255)); while (is_num(c));
        s.push_back(c);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  result_t    pending_lengths[$];   // expected results, oldest first
  logic       req_has_exp = 1'b0;   // travels with the current request
  result_t    req_exp     = '0;
  int         chars_accepted  = 0;
  int         strings_sent    = 0;
  int         n_malformed     = 0;
  int         n_saturated     = 0;
  int         results_checked = 0;
  int         fail_cnt        = 0;

  // Every accepted request steps the parser; end markers queue a result.
  always @(posedge clk_i) begin : char_monitor
    result_t res;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      chars_accepted++;
      if (predict_cigar_char(s_axis_tdata, s_axis_tlast, res)) begin
        strings_sent++;
        if (res.status == ST_MALFORMED) n_malformed++;
        if (res.status == ST_SATURATED) n_saturated++;
        pending_lengths.push_back(req_has_exp ? req_exp : res);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_lengths.size() == 0) begin
        $error("unexpected result: ref_length %0d status %0d",
               $signed(m_axis_tdata), m_axis_tuser);
        fail_cnt++;
      end else begin
        want = pending_lengths.pop_front();
        if (m_axis_tdata !== want.ref_length) begin
          $error("ref_length: expected %0d, got %0d",
                 $signed(want.ref_length), $signed(m_axis_tdata));
          fail_cnt++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_cnt++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side ready: a random stall pattern, redrawn each time rx_tick wraps, plus
  // one long hold-off so the block backs up and drops s_axis_tready.
  // ---------------------------------------------------------------------------
  logic [15:0] rx_pat    = '1;
  logic [5:0]  rx_tick   = '0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin : result_ready
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && chars_accepted >= HOLD_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      if (rx_tick == '0) begin
        case ($urandom_range(0, 3))
          0:       rx_pat <= '1;                                // no stalls
          1:       rx_pat <= 16'($urandom) | 16'h0001;
          2:       rx_pat <= 16'($urandom & $urandom) | 16'h0001; // mostly stalled
          default: rx_pat <= 16'($urandom) | 16'h8000;
        endcase
      end
      m_axis_tready <= rx_pat[rx_tick[3:0]];
      rx_tick       <= rx_tick + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build all strings, reset, send in bursts, drain, report
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    char_req_t  r;
    logic [7:0] s[$];
    result_t    exp;
    int         n_directed;
    int         kind;
    int         burst;
    int         gap;

    foreach (dir_rows[k]) begin
      s.delete();
      for (int i = 0; i < dir_rows[k].text.len(); i++) begin
        s.push_back(i == dir_rows[k].sub_pos ? dir_rows[k].sub_val : 8'(dir_rows[k].text[i]));
      end
      exp.ref_length = dir_rows[k].exp_len;
      exp.status     = dir_rows[k].exp_st;
      push_string(s, dir_rows[k].has_exp, exp);
    end
    n_directed = send_q.size();

    // Random part: mostly well-formed, then noise, broken strings, star forms
    // and empty strings.
    while (send_q.size() < n_directed + N_RAND_CHARS) begin
      s.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_cigar(s);
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        build_cigar(s);
        case ($urandom_range(0, 2))
          0:       void'(s.pop_back());                                  // op lost
          1:       s.push_back($urandom_range(0, 1) ? CH_MINUS : CH_SPACE); // dangling
          default: s.insert($urandom_range(0, s.size()), 8'($urandom_range(0, 255)));
        endcase
      end else if (kind < 95) begin
        s.push_back(CH_STAR);
        if ($urandom_range(0, 1)) s.push_back(8'($urandom_range(0, 255)));
      end
      push_string(s, 1'b0, '0);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Bursts of back-to-back requests with random gaps between them.
    burst = 0;
    while (send_q.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      r = send_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= r.sym;
      s_axis_tlast  <= r.eos;
      req_has_exp   <= r.has_exp;
      req_exp       <= r.exp;
      do @(posedge clk_i); while (!s_axis_tready);
      burst--;
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d characters in %0d strings (%0d malformed, %0d saturated)",
             chars_accepted, strings_sent, n_malformed, n_saturated);
    $display("summary: %0d results checked, %0d mismatches", results_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: fires far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
